>>> hdl/tbma_pkg.sv
// Package for the trimmed burst moving average.
// Holds sizing constants, the window operation codes and the control structs.
// No dependencies; every other file of the block imports it.
package tbma_pkg;

  // Filter sizing
  localparam int BURST_LENGTH = 16;
  localparam int WINDOW_DEPTH = 8;
  localparam int SAMPLE_BITS  = 12;

  // Bursts of two samples or fewer keep every sample
  localparam bit TRIM_ON      = (BURST_LENGTH > 2);
  localparam int MEAN_DIVISOR = TRIM_ON ? BURST_LENGTH - 2 : BURST_LENGTH;

  // Accumulator widths, wide enough that a full burst or window never wraps
  localparam int TOTAL_BITS    = SAMPLE_BITS + $clog2(BURST_LENGTH);
  localparam int WINDOW_BITS   = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int DIVIDEND_BITS = (TOTAL_BITS > WINDOW_BITS) ? TOTAL_BITS : WINDOW_BITS;

  // Divisor widths: the burst divisor and the window fill level
  localparam int FILL_BITS    = $clog2(WINDOW_DEPTH + 1);
  localparam int MDIV_BITS    = $clog2(MEAN_DIVISOR + 1);
  localparam int DIVISOR_BITS = (FILL_BITS > MDIV_BITS) ? FILL_BITS : MDIV_BITS;

  // Counters and indexes
  localparam int SLOT_BITS    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int POS_BITS     = (BURST_LENGTH > 1) ? $clog2(BURST_LENGTH) : 1;
  localparam int ACC_CNT_BITS = $clog2(TOTAL_BITS + 1);
  localparam int DIV_CNT_BITS = $clog2(DIVIDEND_BITS);

  // Operations on the window ring
  typedef enum logic [1:0] {
    WIN_NOP  = 2'd0,
    WIN_READ = 2'd1,
    WIN_DROP = 2'd2,
    WIN_ADD  = 2'd3
  } win_op_t;

  // Control into the burst accumulator
  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctl_t;

  // Status out of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> hdl/tbma_in_if.sv
// Sample channel of the trimmed burst moving average.
// Carries valid, ready and one raw converter sample; uses tbma_pkg.
interface tbma_in_if import tbma_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> hdl/tbma_out_if.sv
// Result channel of the trimmed burst moving average.
// Carries valid, ready and one filtered value; uses tbma_pkg.
interface tbma_out_if import tbma_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] filtered_value;

  modport source (output valid, output filtered_value, input ready);
  modport sink   (input valid, input filtered_value, output ready);
endinterface

>>> hdl/tbma_burst_acc.sv
// Bit-serial burst accumulator: running total, minimum and maximum of a burst.
// One bit per cycle through shift registers, LSB first; uses tbma_pkg.
module tbma_burst_acc import tbma_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  acc_ctl_t               ctl,
  input  logic [SAMPLE_BITS-1:0] sample,
  output unit_stat_t             stat,
  output logic [TOTAL_BITS-1:0]  total,
  output logic [SAMPLE_BITS-1:0] minimum,
  output logic [SAMPLE_BITS-1:0] maximum
);

  logic [SAMPLE_BITS-1:0]  samp_r;
  logic [TOTAL_BITS-1:0]   tot_r;
  logic [SAMPLE_BITS-1:0]  min_r;
  logic [SAMPLE_BITS-1:0]  max_r;
  logic [ACC_CNT_BITS-1:0] cnt_r;
  logic                    busy_r;
  logic                    carry_r;
  logic                    lt_r;
  logic                    gt_r;

  logic sample_phase;
  logic add_phase;
  logic finish;
  logic s_bit;
  logic sum_bit;
  logic carry_nxt;
  logic lt_nxt;
  logic gt_nxt;

  // Bit slice of the current cycle
  always_comb begin
    sample_phase = busy_r && (cnt_r < ACC_CNT_BITS'(SAMPLE_BITS));
    add_phase    = busy_r && (cnt_r < ACC_CNT_BITS'(TOTAL_BITS));
    finish       = busy_r && (cnt_r == ACC_CNT_BITS'(TOTAL_BITS));
    s_bit        = sample_phase & samp_r[0];
    sum_bit      = s_bit ^ tot_r[0] ^ carry_r;
    carry_nxt    = (s_bit & tot_r[0]) | (s_bit & carry_r) | (tot_r[0] & carry_r);
    // Compare LSB first: a higher differing bit overrides lower ones
    lt_nxt       = (~samp_r[0] & min_r[0]) | (~(samp_r[0] ^ min_r[0]) & lt_r);
    gt_nxt       = (samp_r[0] & ~max_r[0]) | (~(samp_r[0] ^ max_r[0]) & gt_r);
  end

  // Sequence the serial pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (finish) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Rotate the sample and the extremes, keep the compare flags
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      samp_r <= sample;
      lt_r   <= 1'b0;
      gt_r   <= 1'b0;
    end else if (sample_phase) begin
      samp_r <= {samp_r[0], samp_r[SAMPLE_BITS-1:1]};
      lt_r   <= lt_nxt;
      gt_r   <= gt_nxt;
    end
  end

  // Burst state: total, minimum, maximum
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      tot_r   <= '0;
      min_r   <= '1;
      max_r   <= '0;
      carry_r <= 1'b0;
    end else if (ctl.start) begin
      carry_r <= 1'b0;
    end else begin
      if (add_phase) begin
        tot_r   <= {sum_bit, tot_r[TOTAL_BITS-1:1]};
        carry_r <= carry_nxt;
      end
      if (sample_phase) begin
        min_r <= {min_r[0], min_r[SAMPLE_BITS-1:1]};
        max_r <= {max_r[0], max_r[SAMPLE_BITS-1:1]};
      end else if (finish) begin
        if (lt_r) min_r <= samp_r;
        if (gt_r) max_r <= samp_r;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = finish;
  assign total     = tot_r;
  assign minimum   = min_r;
  assign maximum   = max_r;

endmodule

>>> hdl/tbma_serial_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Shared by the burst mean and the window average; uses tbma_pkg.
module tbma_serial_div import tbma_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output unit_stat_t               stat,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  logic [DIVIDEND_BITS-1:0] q_r;
  logic [DIVISOR_BITS-1:0]  rem_r;
  logic [DIVISOR_BITS-1:0]  dvs_r;
  logic [DIV_CNT_BITS-1:0]  cnt_r;
  logic                     busy_r;
  logic                     done_r;

  logic [DIVISOR_BITS:0]    shifted;
  logic [DIVISOR_BITS+1:0]  trial;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem_r, q_r[DIVIDEND_BITS-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
  end

  // Count the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_BITS'(DIVIDEND_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the quotient in, keep or restore the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!trial[DIVISOR_BITS+1]) begin
        rem_r <= trial[DIVISOR_BITS-1:0];
        q_r   <= {q_r[DIVIDEND_BITS-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DIVISOR_BITS-1:0];
        q_r   <= {q_r[DIVIDEND_BITS-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

>>> hdl/tbma_window.sv
// Moving-average window: ring store of burst means, running total, fill level.
// Entries past the fill level read as zero, so the store needs no clearing.
// Uses tbma_pkg.
module tbma_window import tbma_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  win_op_t                op,
  input  logic [SAMPLE_BITS-1:0] mean,
  output logic [WINDOW_BITS-1:0] total,
  output logic [FILL_BITS-1:0]   fill
);

  logic [SAMPLE_BITS-1:0] store [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] old_r;
  logic [SLOT_BITS-1:0]   slot_r;
  logic [FILL_BITS-1:0]   fill_r;
  logic [WINDOW_BITS-1:0] total_r;

  logic full;

  assign full = (fill_r == FILL_BITS'(WINDOW_DEPTH));

  // Read the oldest entry, write the new mean in its place
  always_ff @(posedge clk) begin
    if (op == WIN_READ) begin
      if (full) old_r <= store[slot_r];
      else      old_r <= '0;
    end
    if (op == WIN_DROP) begin
      store[slot_r] <= mean;
    end
  end

  // Update total, slot and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      fill_r  <= '0;
      total_r <= '0;
    end else begin
      unique case (op)
        WIN_NOP, WIN_READ: begin
        end
        WIN_DROP: begin
          total_r <= total_r - WINDOW_BITS'(old_r);
          if (slot_r == SLOT_BITS'(WINDOW_DEPTH - 1)) slot_r <= '0;
          else                                        slot_r <= slot_r + 1'b1;
          if (!full) fill_r <= fill_r + 1'b1;
        end
        WIN_ADD: begin
          total_r <= total_r + WINDOW_BITS'(mean);
        end
        default: begin
        end
      endcase
    end
  end

  assign total = total_r;
  assign fill  = fill_r;

endmodule

>>> hdl/trimmed_burst_moving_average.sv
// Top level of the trimmed burst moving average; sequencer and output register.
// Depends on tbma_pkg, tbma_in_if, tbma_out_if, tbma_burst_acc,
// tbma_serial_div and tbma_window.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid / ready  sample          (12 bits, unsigned)
//   out_ch    out  valid / ready  filtered_value  (12 bits, unsigned)
//
// For each sample the bit-serial accumulator walks the burst total one bit
// per cycle; no new sample is taken until the sequencer is idle again. The
// last sample of a burst adds two passes through the serial divider and the
// window update.
// Synchronous active-low reset clears the burst and the window at once.
// A stalled result waits in the output register while new samples are taken;
// the next burst end holds until that result is taken.
module trimmed_burst_moving_average import tbma_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  tbma_in_if.sink    in_ch,
  tbma_out_if.source out_ch
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_ACC       = 12'b0000_0000_0010,
    ST_TRIM_MIN  = 12'b0000_0000_0100,
    ST_TRIM_MAX  = 12'b0000_0000_1000,
    ST_MEAN_GO   = 12'b0000_0001_0000,
    ST_MEAN_WAIT = 12'b0000_0010_0000,
    ST_WIN_READ  = 12'b0000_0100_0000,
    ST_WIN_DROP  = 12'b0000_1000_0000,
    ST_WIN_ADD   = 12'b0001_0000_0000,
    ST_AVG_GO    = 12'b0010_0000_0000,
    ST_AVG_WAIT  = 12'b0100_0000_0000,
    ST_OUT       = 12'b1000_0000_0000
  } state_t;

  state_t                 state_r;
  state_t                 state_nxt;
  logic [POS_BITS-1:0]    pos_r;
  logic [TOTAL_BITS-1:0]  trim_r;
  logic [SAMPLE_BITS-1:0] mean_r;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_value_r;

  logic                     accept;
  logic                     burst_last;
  logic                     out_free;
  acc_ctl_t                 acc_ctl;
  unit_stat_t               acc_stat;
  unit_stat_t               div_stat;
  logic [TOTAL_BITS-1:0]    acc_total;
  logic [SAMPLE_BITS-1:0]   acc_min;
  logic [SAMPLE_BITS-1:0]   acc_max;
  logic                     div_start;
  logic [DIVIDEND_BITS-1:0] div_dividend;
  logic [DIVISOR_BITS-1:0]  div_divisor;
  logic [DIVIDEND_BITS-1:0] div_quotient;
  win_op_t                  win_op;
  logic [WINDOW_BITS-1:0]   win_total;
  logic [FILL_BITS-1:0]     win_fill;

  // Handshakes
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign burst_last  = (pos_r == POS_BITS'(BURST_LENGTH - 1));

  // Drive the serial units
  always_comb begin
    acc_ctl.start = accept;
    acc_ctl.clear = (state_r == ST_TRIM_MAX);
    div_start     = (state_r == ST_MEAN_GO) || (state_r == ST_AVG_GO);
    if (state_r == ST_MEAN_GO) begin
      div_dividend = DIVIDEND_BITS'(trim_r);
      div_divisor  = DIVISOR_BITS'(MEAN_DIVISOR);
    end else begin
      div_dividend = DIVIDEND_BITS'(win_total);
      div_divisor  = DIVISOR_BITS'(win_fill);
    end
    unique case (state_r)
      ST_WIN_READ: win_op = WIN_READ;
      ST_WIN_DROP: win_op = WIN_DROP;
      ST_WIN_ADD:  win_op = WIN_ADD;
      default:     win_op = WIN_NOP;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (accept) state_nxt = ST_ACC;
      ST_ACC: begin
        if (acc_stat.done) state_nxt = burst_last ? ST_TRIM_MIN : ST_IDLE;
      end
      ST_TRIM_MIN:  state_nxt = ST_TRIM_MAX;
      ST_TRIM_MAX:  state_nxt = ST_MEAN_GO;
      ST_MEAN_GO:   state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (div_stat.done) state_nxt = ST_WIN_READ;
      ST_WIN_READ:  state_nxt = ST_WIN_DROP;
      ST_WIN_DROP:  state_nxt = ST_WIN_ADD;
      ST_WIN_ADD:   state_nxt = ST_AVG_GO;
      ST_AVG_GO:    state_nxt = ST_AVG_WAIT;
      ST_AVG_WAIT:  if (div_stat.done) state_nxt = ST_OUT;
      ST_OUT:       if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Advance the state and the burst position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_ACC && acc_stat.done) begin
        if (burst_last) pos_r <= '0;
        else            pos_r <= pos_r + 1'b1;
      end
    end
  end

  // Drop one minimum and one maximum when TRIM_ON, hold the burst mean
  always_ff @(posedge clk) begin
    if (state_r == ST_TRIM_MIN) begin
      if (TRIM_ON) trim_r <= acc_total - TOTAL_BITS'(acc_min);
      else         trim_r <= acc_total;
    end
    if (state_r == ST_TRIM_MAX && TRIM_ON) begin
      trim_r <= trim_r - TOTAL_BITS'(acc_max);
    end
    if (state_r == ST_MEAN_WAIT && div_stat.done) begin
      mean_r <= div_quotient[SAMPLE_BITS-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_value_r <= div_quotient[SAMPLE_BITS-1:0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_value = out_value_r;

  tbma_burst_acc u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (acc_ctl),
    .sample  (in_ch.sample),
    .stat    (acc_stat),
    .total   (acc_total),
    .minimum (acc_min),
    .maximum (acc_max)
  );

  tbma_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  tbma_window u_win (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (win_op),
    .mean  (mean_r),
    .total (win_total),
    .fill  (win_fill)
  );

endmodule

>>> tb/tbma_filter_checker.sv
// Checker for the trimmed burst moving average: predicts each filtered value
// from the accepted samples and compares it with the result channel.
// Depends on tbma_pkg for the filter sizing.
module tbma_filter_checker import tbma_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [SAMPLE_BITS-1:0] out_filtered_value,
  output int                     fail_count,
  output int                     outstanding,
  output int                     checked_count,
  output int                     burst_count
);

  localparam int POSN_BITS = $clog2(BURST_LENGTH + 1);

  // Running burst statistics
  logic [POSN_BITS-1:0]   burst_pos;
  logic [SAMPLE_BITS-1:0] burst_lo;
  logic [SAMPLE_BITS-1:0] burst_hi;
  logic [TOTAL_BITS-1:0]  burst_sum;

  // Window of burst means
  logic [SAMPLE_BITS-1:0] ring [WINDOW_DEPTH];
  logic [SLOT_BITS-1:0]   ring_slot;
  logic [FILL_BITS-1:0]   ring_fill;
  logic [WINDOW_BITS-1:0] ring_sum;

  // Filtered values still owed by the block, oldest first
  logic [SAMPLE_BITS-1:0] expected_averages [$];
  logic [SAMPLE_BITS-1:0] want;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_burst();
    burst_pos = '0;
    burst_lo  = '1;
    burst_hi  = '0;
    burst_sum = '0;
  endtask

  task automatic clear_filter();
    clear_burst();
    foreach (ring[i]) ring[i] = '0;
    ring_slot = '0;
    ring_fill = '0;
    ring_sum  = '0;
    expected_averages.delete();
  endtask

  // Fold one sample into the burst; on the last one push the new average
  task automatic absorb_sample(input logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] average;
    if (s < burst_lo) burst_lo = s;
    if (s > burst_hi) burst_hi = s;
    burst_sum = burst_sum + s;
    burst_pos = burst_pos + 1'b1;
    if (burst_pos == BURST_LENGTH) begin
      // drop one lowest and one highest sample unless the burst is too short
      if (TRIM_ON) mean = SAMPLE_BITS'((burst_sum - burst_lo - burst_hi) / MEAN_DIVISOR);
      else         mean = SAMPLE_BITS'(burst_sum / BURST_LENGTH);
      ring_sum = ring_sum - ring[ring_slot] + mean;
      ring[ring_slot] = mean;
      ring_slot = (ring_slot == SLOT_BITS'(WINDOW_DEPTH - 1)) ? '0 : ring_slot + 1'b1;
      if (ring_fill < WINDOW_DEPTH) ring_fill = ring_fill + 1'b1;
      average = SAMPLE_BITS'(ring_sum / ring_fill);
      expected_averages.push_back(average);
      burst_count++;
      clear_burst();
    end
  endtask

  // Sample both channels mid-cycle, where every signal is settled
  always @(negedge clk) begin
    if (!rst_n) begin
      clear_filter();
    end else begin
      if (in_valid && in_ready) absorb_sample(in_sample);
      if (out_valid && out_ready) begin
        if (expected_averages.size() == 0) begin
          report_mismatch($sformatf("filtered_value %0d arrived with none pending",
                                    out_filtered_value));
        end else begin
          want = expected_averages.pop_front();
          checked_count++;
          if (out_filtered_value !== want)
            report_mismatch($sformatf("filtered_value %0d, predicted %0d",
                                      out_filtered_value, want));
        end
      end
    end
    outstanding = expected_averages.size();
  end

endmodule

>>> tb/tb_top.sv
// Top of the trimmed burst moving average bench: clock, reset, sample and
// ready stimulus, watchdog and verdict.
// Depends on tbma_pkg, tbma_in_if, tbma_out_if, the block and tbma_filter_checker.
module tb_top;
  import tbma_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam int RANDOM_BURSTS  = 87;
  localparam int IDLE_PERCENT   = 34;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 120;

  typedef enum int {
    SHAPE_UNIFORM,
    SHAPE_CONSTANT,
    SHAPE_LOW,
    SHAPE_HIGH,
    SHAPE_TWO_LEVEL,
    SHAPE_FULL_SCALE
  } burst_shape_t;

  logic clk;
  logic rst_n;
  logic steady;
  int   stall_cycles;
  int   samples_sent;
  int   fail_count;
  int   outstanding;
  int   checked_count;
  int   burst_count;
  int   pick;
  burst_shape_t shape;

  // Extremes, repeated minimum and maximum, and alternating bit patterns
  logic [SAMPLE_BITS-1:0] directed_samples [16] = '{
    SAMPLE_MAX, 0, 0, SAMPLE_MAX, 12'hAAA, 12'h555, 1, SAMPLE_MAX - 1,
    2048, 2047, 100, 3000, 7, 4000, 1234, 0
  };

  tbma_in_if  in_ch ();
  tbma_out_if out_ch ();

  trimmed_burst_moving_average dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tbma_filter_checker filter_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_sample          (in_ch.sample),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_filtered_value (out_ch.filtered_value),
    .fail_count         (fail_count),
    .outstanding        (outstanding),
    .checked_count      (checked_count),
    .burst_count        (burst_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result channel at random, except during the steady stretch
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Abort when no request moves on either channel for too long
  always @(negedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", stall_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one sample request, with random gaps before it, and hold until taken
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
    logic taken;
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= value;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    samples_sent++;
  endtask

  // Send one full burst whose content follows the chosen shape
  task automatic send_burst(input burst_shape_t kind);
    logic [SAMPLE_BITS-1:0] level_a;
    logic [SAMPLE_BITS-1:0] level_b;
    logic [SAMPLE_BITS-1:0] value;
    int                     coin;
    level_a = SAMPLE_BITS'($urandom_range(SAMPLE_MAX, 0));
    level_b = SAMPLE_BITS'($urandom_range(SAMPLE_MAX, level_a));
    for (int i = 0; i < BURST_LENGTH; i++) begin
      case (kind)
        SHAPE_UNIFORM:    value = SAMPLE_BITS'($urandom);
        SHAPE_CONSTANT:   value = level_a;
        SHAPE_LOW:        value = SAMPLE_BITS'($urandom_range(15, 0));
        SHAPE_HIGH:       value = SAMPLE_BITS'($urandom_range(SAMPLE_MAX, SAMPLE_MAX - 15));
        SHAPE_TWO_LEVEL: begin
          // repeat both extremes several times inside one burst
          coin = $urandom_range(3, 0);
          if (coin == 0)      value = level_a;
          else if (coin == 1) value = level_b;
          else                value = SAMPLE_BITS'($urandom_range(level_b, level_a));
        end
        default:          value = SAMPLE_MAX;
      endcase
      send_sample(value);
    end
  endtask

  // Drop valid and hold the sender until every filtered value has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    rst_n        = 1'b0;
    steady       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_samples[i]) send_sample(directed_samples[i]);
    wait_drained();

    for (int b = 0; b < RANDOM_BURSTS; b++) begin
      steady <= (b >= 30 && b < 42);
      pick = $urandom_range(9, 0);
      case (pick)
        0, 1, 2, 3: shape = SHAPE_UNIFORM;
        4:          shape = SHAPE_CONSTANT;
        5:          shape = SHAPE_LOW;
        6:          shape = SHAPE_HIGH;
        7, 8:       shape = SHAPE_TWO_LEVEL;
        default:    shape = SHAPE_FULL_SCALE;
      endcase
      send_burst(shape);
      if (b % 20 == 19) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples forming %0d bursts; %0d filtered values compared",
             samples_sent, burst_count, checked_count);
    $display("Stimulus mixed uniform, constant, edge-of-range and two-level bursts");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
